>>> rtl/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg: shared constants and tables
// Widths, CORDIC constants and the arctangent table for the RPY unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package erm_pkg;

    localparam int CORDIC_STEPS     = 16;
    localparam int MATRIX_FRAC_BITS = 14;
    localparam int WORK_FRAC        = 30;
    localparam int EMIT_SHIFT       = WORK_FRAC - MATRIX_FRAC_BITS;

    localparam int ANG_W  = 15;
    localparam int POS_W  = 32;
    localparam int ENT_W  = 16;
    localparam int CW     = 32;   // cordic x/y, Q30
    localparam int ZW     = 24;   // cordic angle, 2^-16 degree
    localparam int PW     = 34;   // rounded Q30 products and sums
    localparam int WIDE_W = 2 * PW;

    localparam int ANG_FULL    = 23040;
    localparam int ANG_QUARTER = 5760;
    localparam int ANG_EIGHTH  = 2880;

    localparam logic signed [CW-1:0] CORDIC_X0 = 32'sd652032874;

    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int MATRIX_LAT = 5;
    localparam int TOTAL_LAT  = CORDIC_LAT + MATRIX_LAT;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [PW-1:0] pval_t;
    typedef logic signed [ENT_W-1:0] ent_t;

    typedef struct packed {
        cval_t c;
        cval_t s;
    } trig_t;

    function automatic logic signed [ZW-1:0] atan_deg16(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = 24'sd2949120;
            1:  v = 24'sd1740967;
            2:  v = 24'sd919879;
            3:  v = 24'sd466945;
            4:  v = 24'sd234379;
            5:  v = 24'sd117304;
            6:  v = 24'sd58666;
            7:  v = 24'sd29335;
            8:  v = 24'sd14668;
            9:  v = 24'sd7334;
            10: v = 24'sd3667;
            11: v = 24'sd1833;
            12: v = 24'sd917;
            13: v = 24'sd458;
            14: v = 24'sd229;
            15: v = 24'sd115;
            16: v = 24'sd57;
            17: v = 24'sd29;
            18: v = 24'sd14;
            19: v = 24'sd7;
            20: v = 24'sd4;
            21: v = 24'sd2;
            22: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/euler_rpy_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// euler_rpy_to_rotation_matrix_unit: roll/pitch/yaw to rotation matrix
// Three CORDIC lanes for sin/cos, a product/merge pipeline, positions bypassed.
// ----------------------------------------------------------------------------
// Pipeline from accepted input word to output word: fold stage, one stage
// per CORDIC step, quadrant swap, five product/round/emit stages.
// Throughput: one word per cycle; the whole pipeline holds while the output
// word waits, so s_tready follows m_tready when m_tvalid is high.
// Reset: rst_n clears the valid chain only; datapath registers are not reset.
`timescale 1ns / 1ps
module euler_rpy_to_rotation_matrix_unit
    import erm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // x_position[31:0], y_position[63:32], z_position[95:64], roll_angle[110:96],
    // pitch_angle[125:111], yaw_angle[140:126], zero[143:141]
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r00[15:0] r01 r02 r10 r11 r12 r20 r21 r22[143:128],
    // out_x[175:144], out_y[207:176], out_z[239:208]
    output logic [239:0] m_tdata
);

    logic                  en;
    logic [TOTAL_LAT-1:0]  vld_reg;
    logic [TOTAL_LAT-1:0]  vld_next;
    logic [3*POS_W-1:0]    pos_reg [0:TOTAL_LAT-1];
    trig_t                 roll_t, pitch_t, yaw_t;
    ent_t                  ent [0:8];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign vld_next = {vld_reg[TOTAL_LAT-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= s_tdata[95:0];
            for (int k = 1; k < TOTAL_LAT; k++)
            begin
                pos_reg[k] <= pos_reg[k-1];
            end
        end
    end

    erm_cordic u_roll
    (
        .clk   (clk),
        .en    (en),
        .angle (s_tdata[110:96]),
        .trig  (roll_t)
    );

    erm_cordic u_pitch
    (
        .clk   (clk),
        .en    (en),
        .angle (s_tdata[125:111]),
        .trig  (pitch_t)
    );

    erm_cordic u_yaw
    (
        .clk   (clk),
        .en    (en),
        .angle (s_tdata[140:126]),
        .trig  (yaw_t)
    );

    erm_matrix u_matrix
    (
        .clk   (clk),
        .en    (en),
        .roll  (roll_t),
        .pitch (pitch_t),
        .yaw   (yaw_t),
        .ent   (ent)
    );

    assign m_tdata = {pos_reg[TOTAL_LAT-1],
                      ent[8], ent[7], ent[6], ent[5], ent[4],
                      ent[3], ent[2], ent[1], ent[0]};

endmodule

>>> rtl/erm_cordic.sv
// ----------------------------------------------------------------------------
// erm_cordic: one sine/cosine lane
// Angle wrap and octant fold, pipelined rotation CORDIC, quadrant swap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module erm_cordic
    import erm_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output trig_t                   trig
);

    logic signed [16:0] a_ext;
    logic signed [16:0] r_wrap;
    logic        [1:0]  q_raw;
    logic signed [16:0] t_raw;
    logic        [1:0]  q_fix;
    logic signed [16:0] t_fix;

    cval_t                x_reg [0:CORDIC_STEPS];
    cval_t                y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic        [1:0]    q_reg [0:CORDIC_STEPS];
    trig_t                trig_reg;

    always_comb
    begin
        a_ext  = 17'(angle);
        r_wrap = (a_ext < 0) ? a_ext + 17'sd23040 : a_ext;
        if (r_wrap >= 17'sd17280)
        begin
            q_raw = 2'd3;
            t_raw = r_wrap - 17'sd17280;
        end
        else if (r_wrap >= 17'sd11520)
        begin
            q_raw = 2'd2;
            t_raw = r_wrap - 17'sd11520;
        end
        else if (r_wrap >= 17'sd5760)
        begin
            q_raw = 2'd1;
            t_raw = r_wrap - 17'sd5760;
        end
        else
        begin
            q_raw = 2'd0;
            t_raw = r_wrap;
        end
        if (t_raw > 17'sd2880)
        begin
            t_fix = t_raw - 17'sd5760;
            q_fix = q_raw + 2'd1;
        end
        else
        begin
            t_fix = t_raw;
            q_fix = q_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= ZW'(t_fix) <<< 10;
            q_reg[0] <= q_fix;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_deg16(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_deg16(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (q_reg[CORDIC_STEPS])
                2'd0:    trig_reg <= '{c: x_reg[CORDIC_STEPS],  s: y_reg[CORDIC_STEPS]};
                2'd1:    trig_reg <= '{c: -y_reg[CORDIC_STEPS], s: x_reg[CORDIC_STEPS]};
                2'd2:    trig_reg <= '{c: -x_reg[CORDIC_STEPS], s: -y_reg[CORDIC_STEPS]};
                default: trig_reg <= '{c: y_reg[CORDIC_STEPS],  s: -x_reg[CORDIC_STEPS]};
            endcase
        end
    end

    assign trig = trig_reg;

endmodule

>>> rtl/erm_matrix.sv
// ----------------------------------------------------------------------------
// erm_matrix: merge of the three lanes
// Pipelined products R = Rz*Ry*Rx, rounding and saturation of the nine entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module erm_matrix
    import erm_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  trig_t roll,
    input  trig_t pitch,
    input  trig_t yaw,
    output ent_t  ent [0:8]
);

    // stage A products: 0 spsr 1 spcr 2 cycp 3 sycp 4 cpsr 5 cpcr 6 sycr 7 sysr 8 cycr 9 cysr
    logic signed [WIDE_W-1:0] pa_reg [0:9];
    cval_t                    cy_a_reg, sy_a_reg, sp_a_reg;
    pval_t                    pb_reg [0:9];
    cval_t                    cy_b_reg, sy_b_reg, sp_b_reg;
    // stage C: 0 cy*spsr 1 cy*spcr 2 sy*spsr 3 sy*spcr
    logic signed [WIDE_W-1:0] pc_reg [0:3];
    // kept: 0 cycp 1 sycp 2 -sp 3 cpsr 4 sycr 5 sysr 6 cycr 7 cysr 8 cpcr
    pval_t                    pc_keep_reg [0:8];
    pval_t                    sum_reg [0:8];
    ent_t                     ent_reg [0:8];

    function automatic pval_t rnd30(input logic signed [WIDE_W-1:0] p);
        logic signed [WIDE_W-1:0] t;
        t = (p + (WIDE_W'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
        return PW'(t);
    endfunction

    function automatic ent_t emit(input pval_t v);
        logic signed [PW+1:0] w;
        logic signed [PW+1:0] lim;
        w   = (PW+2)'(v);
        if (EMIT_SHIFT > 0)
        begin
            w = (w + ((PW+2)'(1) <<< (EMIT_SHIFT > 0 ? EMIT_SHIFT - 1 : 0))) >>> EMIT_SHIFT;
        end
        lim = (PW+2)'(1) <<< MATRIX_FRAC_BITS;
        if (w > lim)
        begin
            w = lim;
        end
        if (w < -lim)
        begin
            w = -lim;
        end
        if (w > 32767)
        begin
            w = 32767;
        end
        if (w < -32768)
        begin
            w = -32768;
        end
        return ENT_W'(w);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= WIDE_W'(pitch.s) * WIDE_W'(roll.s);
            pa_reg[1] <= WIDE_W'(pitch.s) * WIDE_W'(roll.c);
            pa_reg[2] <= WIDE_W'(yaw.c) * WIDE_W'(pitch.c);
            pa_reg[3] <= WIDE_W'(yaw.s) * WIDE_W'(pitch.c);
            pa_reg[4] <= WIDE_W'(pitch.c) * WIDE_W'(roll.s);
            pa_reg[5] <= WIDE_W'(pitch.c) * WIDE_W'(roll.c);
            pa_reg[6] <= WIDE_W'(yaw.s) * WIDE_W'(roll.c);
            pa_reg[7] <= WIDE_W'(yaw.s) * WIDE_W'(roll.s);
            pa_reg[8] <= WIDE_W'(yaw.c) * WIDE_W'(roll.c);
            pa_reg[9] <= WIDE_W'(yaw.c) * WIDE_W'(roll.s);
            cy_a_reg  <= yaw.c;
            sy_a_reg  <= yaw.s;
            sp_a_reg  <= pitch.s;

            for (int k = 0; k < 10; k++)
            begin
                pb_reg[k] <= rnd30(pa_reg[k]);
            end
            cy_b_reg <= cy_a_reg;
            sy_b_reg <= sy_a_reg;
            sp_b_reg <= sp_a_reg;

            pc_reg[0] <= WIDE_W'(cy_b_reg) * WIDE_W'(pb_reg[0]);
            pc_reg[1] <= WIDE_W'(cy_b_reg) * WIDE_W'(pb_reg[1]);
            pc_reg[2] <= WIDE_W'(sy_b_reg) * WIDE_W'(pb_reg[0]);
            pc_reg[3] <= WIDE_W'(sy_b_reg) * WIDE_W'(pb_reg[1]);
            pc_keep_reg[0] <= pb_reg[2];
            pc_keep_reg[1] <= pb_reg[3];
            pc_keep_reg[2] <= -PW'(sp_b_reg);
            pc_keep_reg[3] <= pb_reg[4];
            pc_keep_reg[4] <= pb_reg[6];
            pc_keep_reg[5] <= pb_reg[7];
            pc_keep_reg[6] <= pb_reg[8];
            pc_keep_reg[7] <= pb_reg[9];
            pc_keep_reg[8] <= pb_reg[5];

            sum_reg[0] <= pc_keep_reg[0];
            sum_reg[1] <= rnd30(pc_reg[0]) - pc_keep_reg[4];
            sum_reg[2] <= rnd30(pc_reg[1]) + pc_keep_reg[5];
            sum_reg[3] <= pc_keep_reg[1];
            sum_reg[4] <= rnd30(pc_reg[2]) + pc_keep_reg[6];
            sum_reg[5] <= rnd30(pc_reg[3]) - pc_keep_reg[7];
            sum_reg[6] <= pc_keep_reg[2];
            sum_reg[7] <= pc_keep_reg[3];
            sum_reg[8] <= pc_keep_reg[8];

            for (int k = 0; k < 9; k++)
            begin
                ent_reg[k] <= emit(sum_reg[k]);
            end
        end
    end

    assign ent = ent_reg;

endmodule

>>> rtl/erm_checker.sv
// ----------------------------------------------------------------------------
// erm_checker: port-level checks
// Handshake coupling, output hold, reset and r20 entry range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module erm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [143:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [239:0] m_tdata
);

    a_ready_follows : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready not tied to output stall");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset : assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("m_tvalid during reset");

    a_r20_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[111:96]) <= 16'sd16384)
                  && ($signed(m_tdata[111:96]) >= -16'sd16384))
        else $error("r20 outside unit range");

endmodule

bind euler_rpy_to_rotation_matrix_unit erm_checker u_erm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
